// ----- sv/mrfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfe_pkg
// Shared types, constants and the CRC-8 step for the request frame encoder.
// ----------------------------------------------------------------------------
package mrfe_pkg;

    localparam int MAX_DATA_BYTES_DEF = 4;
    localparam int HEADER_LEN         = 12;   // payload bytes ahead of the data bytes
    localparam int CFG_W              = 32;
    localparam int CFG_IDX_W          = 1;

    localparam logic [CFG_IDX_W-1:0] REG_METER_ADDRESS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCESS_PASSWORD = 1'b1;

    localparam logic [7:0] FRAME_MARK   = 8'hC0;
    localparam logic [7:0] ESC_MARK     = 8'hDB;
    localparam logic [7:0] ESC_FOR_MARK = 8'hDC;
    localparam logic [7:0] ESC_FOR_ESC  = 8'hDD;
    localparam logic [7:0] OPT_BYTE     = 8'h48;
    localparam logic [7:0] SOURCE_ADDR  = 8'd253;
    localparam logic [7:0] SERVICE_BASE = 8'hD0;
    localparam logic [7:0] CRC_POLY     = 8'hB5;

    typedef struct packed {
        logic [15:0] command_code;
        logic [2:0]  data_count;
        logic [31:0] data_word;
    } request_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
    } result_t;

    typedef struct packed {
        logic load;
        logic emit_open;
        logic emit_body;
        logic emit_close;
    } ctrl_cmd_t;

    typedef struct packed {
        logic body_last;
    } dp_status_t;

    // CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- sv/mrfe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfe_ctrl
// Frame sequencer: opening mark, stuffed payload, closing mark.
// ----------------------------------------------------------------------------
module mrfe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   cmd_nonzero,
    input  mrfe_pkg::dp_status_t   status,
    output mrfe_pkg::ctrl_cmd_t    cmd,
    output logic                   busy
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_OPEN  = 4'b0010,
        ST_BODY  = 4'b0100,
        ST_CLOSE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.emit_open  = 1'b0;
        cmd.emit_body  = 1'b0;
        cmd.emit_close = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // a zero command is taken and dropped
                if (accept && cmd_nonzero)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_OPEN;
                end
            end
            ST_OPEN:
            begin
                cmd.emit_open = 1'b1;
                state_next    = ST_BODY;
            end
            ST_BODY:
            begin
                cmd.emit_body = 1'b1;
                if (status.body_last)
                    state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                cmd.emit_close = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_load_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_nonzero) |=> (state_reg == ST_OPEN))
        else $error("accepted request did not open a frame");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BODY && status.body_last) |=> (state_reg == ST_CLOSE))
        else $error("last payload beat did not lead to the closing mark");

    a_close_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after closing mark");

endmodule

// ----- sv/mrfe_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfe_datapath
// Config registers, payload byte select, CRC-8 and byte stuffing.
// ----------------------------------------------------------------------------
module mrfe_datapath #(
    parameter int MAX_DATA_BYTES = mrfe_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mrfe_pkg::request_t                request,
    input  mrfe_pkg::ctrl_cmd_t               cmd,
    output mrfe_pkg::dp_status_t              status,
    input  logic                              wr_en,
    input  logic [mrfe_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [mrfe_pkg::CFG_W-1:0]        wr_data,
    output logic                              strobe,
    output mrfe_pkg::result_t                 result
);

    localparam int IDX_W = $clog2(mrfe_pkg::HEADER_LEN + MAX_DATA_BYTES + 1);

    logic [15:0]      addr_reg;
    logic [31:0]      pwd_reg;
    logic [15:0]      cmd_reg;
    logic [2:0]       cnt_reg;
    logic [31:0]      data_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic             esc_pend_reg;
    logic             esc_pend_next;
    logic [7:0]       esc_code_reg;
    logic [7:0]       esc_code_next;
    logic             strobe_reg;
    mrfe_pkg::result_t result_reg;
    mrfe_pkg::result_t result_next;

    logic [2:0]       cnt_sat;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] data_pos;
    logic [7:0]       pay_byte;
    logic             is_mark;
    logic             advance;

    always_comb
    begin
        if (32'(request.data_count) > 32'(MAX_DATA_BYTES))
            cnt_sat = 3'(MAX_DATA_BYTES);
        else
            cnt_sat = request.data_count;
    end

    assign last_idx = IDX_W'(mrfe_pkg::HEADER_LEN) + IDX_W'(cnt_reg);
    assign data_pos = idx_reg - IDX_W'(mrfe_pkg::HEADER_LEN);

    always_comb
    begin
        case (idx_reg)
            IDX_W'(0):  pay_byte = mrfe_pkg::OPT_BYTE;
            IDX_W'(1):  pay_byte = addr_reg[7:0];
            IDX_W'(2):  pay_byte = addr_reg[15:8];
            IDX_W'(3):  pay_byte = mrfe_pkg::SOURCE_ADDR;
            IDX_W'(4):  pay_byte = 8'h00;
            IDX_W'(5):  pay_byte = pwd_reg[7:0];
            IDX_W'(6):  pay_byte = pwd_reg[15:8];
            IDX_W'(7):  pay_byte = pwd_reg[23:16];
            IDX_W'(8):  pay_byte = pwd_reg[31:24];
            IDX_W'(9):  pay_byte = mrfe_pkg::SERVICE_BASE | {5'b0, cnt_reg};
            IDX_W'(10): pay_byte = cmd_reg[15:8];
            IDX_W'(11): pay_byte = cmd_reg[7:0];
            default:
            begin
                if (idx_reg == last_idx)
                    pay_byte = crc_reg;
                else if (data_pos < IDX_W'(4))
                    pay_byte = data_reg[{data_pos[1:0], 3'b000} +: 8];
                else
                    pay_byte = 8'h00;   // beyond the 32-bit data word
            end
        endcase
    end

    assign is_mark = (pay_byte == mrfe_pkg::FRAME_MARK) || (pay_byte == mrfe_pkg::ESC_MARK);
    assign advance = esc_pend_reg || !is_mark;
    assign status.body_last = advance && (idx_reg == last_idx);

    always_comb
    begin
        idx_next               = idx_reg;
        crc_next               = crc_reg;
        esc_pend_next          = esc_pend_reg;
        esc_code_next          = esc_code_reg;
        result_next.line_byte  = mrfe_pkg::FRAME_MARK;
        result_next.frame_end  = 1'b0;
        if (cmd.load)
        begin
            idx_next      = '0;
            crc_next      = 8'h00;
            esc_pend_next = 1'b0;
        end
        if (cmd.emit_close)
            result_next.frame_end = 1'b1;
        if (cmd.emit_body)
        begin
            if (esc_pend_reg)
            begin
                // second half of an escape pair
                result_next.line_byte = esc_code_reg;
                esc_pend_next         = 1'b0;
                idx_next              = idx_reg + IDX_W'(1);
            end
            else
            begin
                crc_next = mrfe_pkg::crc8_update(crc_reg, pay_byte);
                if (is_mark)
                begin
                    result_next.line_byte = mrfe_pkg::ESC_MARK;
                    esc_pend_next         = 1'b1;
                    esc_code_next         = (pay_byte == mrfe_pkg::FRAME_MARK) ?
                                            mrfe_pkg::ESC_FOR_MARK : mrfe_pkg::ESC_FOR_ESC;
                end
                else
                begin
                    result_next.line_byte = pay_byte;
                    idx_next              = idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            pwd_reg      <= '0;
            idx_reg      <= '0;
            crc_reg      <= '0;
            esc_pend_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_index == mrfe_pkg::REG_METER_ADDRESS)
                addr_reg <= wr_data[15:0];
            if (wr_en && wr_index == mrfe_pkg::REG_ACCESS_PASSWORD)
                pwd_reg <= wr_data;
            idx_reg      <= idx_next;
            crc_reg      <= crc_next;
            esc_pend_reg <= esc_pend_next;
            strobe_reg   <= cmd.emit_open || cmd.emit_body || cmd.emit_close;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= request.command_code;
            cnt_reg  <= cnt_sat;
            data_reg <= request.data_word;
        end
        esc_code_reg <= esc_code_next;
        result_reg   <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_pend_after_esc: assert property (@(posedge clk) disable iff (!rst_n)
        esc_pend_reg |-> (strobe_reg && result_reg.line_byte == mrfe_pkg::ESC_MARK))
        else $error("escape pending without an escape beat on the line");

    a_pend_once: assert property (@(posedge clk) disable iff (!rst_n)
        (esc_pend_reg && cmd.emit_body) |=> !esc_pend_reg)
        else $error("escape pair not completed in the next beat");

    a_end_is_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.frame_end) |-> (result_reg.line_byte == mrfe_pkg::FRAME_MARK))
        else $error("frame end flagged on a byte other than the frame mark");

endmodule

// ----- sv/meter_request_frame_encoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_request_frame_encoder_unit
// Builds a stuffed request frame with CRC-8 and sends it one byte a cycle.
// ----------------------------------------------------------------------------
// The edge that accepts start moves the sequencer to its opening state; the opening
// mark is then strobed from the output register. Throughput: one line byte per cycle;
//   a request of N line bytes (15 to 32) keeps busy high from its opening to its closing
//   state, so the byte sequencer driving the single output register takes a new request
//   only after the last is done. A zero command is accepted and produces no beats.
// Reset clears the sequencer and both config registers; the receiver cannot stall.
module meter_request_frame_encoder_unit #(
    parameter int MAX_DATA_BYTES = mrfe_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  mrfe_pkg::request_t                request,
    output logic                              busy,
    output logic                              strobe,
    output mrfe_pkg::result_t                 result,
    input  logic                              wr_en,
    input  logic [mrfe_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [mrfe_pkg::CFG_W-1:0]        wr_data
);

    mrfe_pkg::ctrl_cmd_t  cmd;
    mrfe_pkg::dp_status_t status;
    logic                 cmd_nonzero;

    assign cmd_nonzero = |request.command_code;

    mrfe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd_nonzero (cmd_nonzero),
        .status      (status),
        .cmd         (cmd),
        .busy        (busy)
    );

    mrfe_datapath #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cmd      (cmd),
        .status   (status),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .strobe   (strobe),
        .result   (result)
    );

endmodule
